### hdl/lcgrr_pkg.sv
// shared types and constants for the range-limited lcg random block
// no dependencies; used by lcgrr_mul, lcgrr_div and lcg_random_range
`timescale 1ns / 1ps

package lcgrr_pkg;

   // generator constants
   localparam int unsigned MUL_BITS = 18;
   localparam logic [MUL_BITS-1:0] LCG_MUL = 18'd214013;
   localparam logic [31:0] LCG_INC = 32'd2531011;
   localparam int unsigned MIX_SHIFT = 15;
   localparam int unsigned FRAC_SHIFT = 16;
   localparam logic [31:0] FRAC_DIV = 32'd65535;

   // serial multiplier: 33-bit multiplicand, 18-bit multiplier, 49-bit product
   localparam int unsigned MCAND_W = 33;
   localparam int unsigned PROD_W = 49;
   localparam int unsigned MUL_CNT_W = $clog2(MUL_BITS + 1);

   // restoring divider: 49-bit dividend, 32-bit divisor
   localparam int unsigned DIVD_W = PROD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIVD_W + 1);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_INT = DIV_CNT_W'(32);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FIX = DIV_CNT_W'(DIVD_W);
   localparam int unsigned INT_ALIGN = DIVD_W - 32;

   // register map
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_START = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK = 8'd1;

   localparam logic KIND_INT = 1'b0;
   localparam logic KIND_FIX = 1'b1;

   typedef struct packed {
      logic kind;
      logic [31:0] int_low;
      logic [31:0] int_high;
      logic signed [31:0] fix_low;
      logic signed [31:0] fix_high;
   } req_type;

   typedef struct packed {
      logic [31:0] int_value;
      logic signed [31:0] fix_value;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### hdl/lcgrr_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on lcgrr_pkg
`timescale 1ns / 1ps

module lcgrr_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lcgrr_pkg::MCAND_W-1:0]      mcand,
   input  logic [lcgrr_pkg::MUL_BITS-1:0]     mplier,
   output lcgrr_pkg::unit_stat_type           stat,
   output logic [lcgrr_pkg::PROD_W-1:0]       product
);

   logic [lcgrr_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [lcgrr_pkg::MCAND_W-1:0] mc_ff;
   logic [lcgrr_pkg::MUL_BITS-1:0] mp_ff;
   logic [lcgrr_pkg::MUL_CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [lcgrr_pkg::PROD_W-1:0] addend;

   always_comb begin
      addend = mp_ff[lcgrr_pkg::MUL_BITS-1]
               ? {{(lcgrr_pkg::PROD_W - lcgrr_pkg::MCAND_W){1'b0}}, mc_ff}
               : '0;
      acc_in = {acc_ff[lcgrr_pkg::PROD_W-2:0], 1'b0} + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= lcgrr_pkg::MUL_CNT_W'(lcgrr_pkg::MUL_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == lcgrr_pkg::MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mc_ff  <= mcand;
         mp_ff  <= mplier;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         mp_ff  <= {mp_ff[lcgrr_pkg::MUL_BITS-2:0], 1'b0};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

### hdl/lcgrr_div.sv
// restoring divider, one quotient bit per cycle, shared by modulo and scaling
// depends on lcgrr_pkg
`timescale 1ns / 1ps

module lcgrr_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lcgrr_pkg::DIVD_W-1:0]       dividend,
   input  logic [31:0]                        divisor,
   input  logic [lcgrr_pkg::DIV_CNT_W-1:0]    steps,
   output lcgrr_pkg::unit_stat_type           stat,
   output logic [lcgrr_pkg::DIVD_W-1:0]       quotient,
   output logic [31:0]                        remainder
);

   logic [lcgrr_pkg::DIVD_W-1:0] dq_ff, dq_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff;
   logic [lcgrr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [32:0] trial;
   logic [32:0] diff;
   logic fits;

   always_comb begin
      trial  = {rem_ff, dq_ff[lcgrr_pkg::DIVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      // partial remainder stays below the divisor, so 32 bits hold it
      rem_in = fits ? diff[31:0] : trial[31:0];
      dq_in  = {dq_ff[lcgrr_pkg::DIVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == lcgrr_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

### hdl/lcg_random_range.sv
// top level of the range-limited lcg random block: sequencer, state, registers
// depends on lcgrr_pkg, lcgrr_mul and lcgrr_div
`timescale 1ns / 1ps

// Returns one random value per request, integer or signed Q16.16, drawn from a
// 32-bit linear congruential generator (s = 214013*s + 2531011 mod 2^32) and
// folded into the range the request carries. Equal bounds return the low bound
// without advancing the generator. Otherwise the generator advances through an
// 18-step bit-serial multiplier, then an integer request takes a 32-step
// restoring divide for the modulo, and a fractional request takes a second
// 18-step multiply for the scaling product and a 49-step divide by 65535.
// One request is worked on at a time; req_stall stays high until the result
// is handed to the output register, which holds it while rsp_stall is high,
// so the next request may already be taken. Writing start_value reloads the
// generator (fallback_value if the written value is zero); writes are meant
// only while no request is in flight, and csr_ready is always high.

module lcg_random_range (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lcgrr_pkg::req_type                req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lcgrr_pkg::rsp_type                rsp_data,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lcgrr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ADV_GO   = 3'd1;  // launch generator advance
   localparam logic [2:0] ST_ADV_RUN  = 3'd2;
   localparam logic [2:0] ST_PROD_GO  = 3'd3;  // launch scaling product
   localparam logic [2:0] ST_PROD_RUN = 3'd4;
   localparam logic [2:0] ST_DIV_GO   = 3'd5;  // launch modulo or divide by 65535
   localparam logic [2:0] ST_DIV_RUN  = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;  // result waits for output register

   logic [2:0] state_ff, state_in;

   // generator and registers
   logic [31:0] gen_state_ff, gen_state_in;
   logic [31:0] fallback_ff;

   // captured request
   logic        kind_ff;
   logic [31:0] lo_ff;       // low bound of the selected kind
   logic [31:0] span_ff;     // integer modulus, wraps at 32 bits
   logic [32:0] d_mag_ff;    // magnitude of the exact fractional difference
   logic        d_neg_ff;

   // finished result and output register
   lcgrr_pkg::rsp_type res_ff, res_in;
   lcgrr_pkg::rsp_type rsp_data_ff;
   logic rsp_valid_ff, rsp_valid_in;

   // handshakes
   logic req_take;
   logic csr_take;
   logic out_free;
   logic bounds_equal;

   // fractional difference, 33-bit signed
   logic [32:0] d_full;
   logic [32:0] d_abs;

   // arithmetic units
   logic mul_start;
   logic [lcgrr_pkg::MCAND_W-1:0] mul_mcand;
   logic [lcgrr_pkg::MUL_BITS-1:0] mul_mplier;
   lcgrr_pkg::unit_stat_type mul_stat;
   logic [lcgrr_pkg::PROD_W-1:0] mul_prod;

   logic div_start;
   logic [lcgrr_pkg::DIVD_W-1:0] div_dividend;
   logic [31:0] div_divisor;
   logic [lcgrr_pkg::DIV_CNT_W-1:0] div_steps;
   lcgrr_pkg::unit_stat_type div_stat;
   logic [lcgrr_pkg::DIVD_W-1:0] div_quot;
   logic [31:0] div_rem;

   // result shaping
   logic [31:0] mixed;
   logic [31:0] q_low;
   logic [31:0] q_signed;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // exact difference of the fractional bounds, split into sign and magnitude
   assign d_full = {req_data.fix_high[31], req_data.fix_high}
                 - {req_data.fix_low[31], req_data.fix_low};
   assign d_abs  = d_full[32] ? (~d_full + 33'd1) : d_full;

   assign bounds_equal = (req_data.kind == lcgrr_pkg::KIND_INT)
                         ? (req_data.int_low == req_data.int_high)
                         : (req_data.fix_low == req_data.fix_high);

   // xor-shift mix of the fresh state for the integer kind
   assign mixed = gen_state_ff ^ (gen_state_ff >> lcgrr_pkg::MIX_SHIFT);

   // multiplier operands: advance uses s * 214013, scaling uses (s >> 16) * |d|
   assign mul_start  = (state_ff == ST_ADV_GO) || (state_ff == ST_PROD_GO);
   assign mul_mcand  = (state_ff == ST_PROD_GO) ? d_mag_ff : {1'b0, gen_state_ff};
   assign mul_mplier = (state_ff == ST_PROD_GO)
                       ? {2'b00, gen_state_ff[31:lcgrr_pkg::FRAC_SHIFT]}
                       : lcgrr_pkg::LCG_MUL;

   // divider operands: modulo by span, or product divided by 65535
   assign div_start    = (state_ff == ST_DIV_GO);
   assign div_dividend = (kind_ff == lcgrr_pkg::KIND_FIX)
                         ? mul_prod
                         : {mixed, {lcgrr_pkg::INT_ALIGN{1'b0}}};
   assign div_divisor  = (kind_ff == lcgrr_pkg::KIND_FIX) ? lcgrr_pkg::FRAC_DIV : span_ff;
   assign div_steps    = (kind_ff == lcgrr_pkg::KIND_FIX)
                         ? lcgrr_pkg::DIV_STEPS_FIX
                         : lcgrr_pkg::DIV_STEPS_INT;

   // quotient magnitude never exceeds 2^32; only its low word reaches the sum
   assign q_low    = div_quot[31:0];
   assign q_signed = d_neg_ff ? (~q_low + 32'd1) : q_low;

   lcgrr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   lcgrr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // sequencer, generator state and result
   always_comb begin
      state_in     = state_ff;
      gen_state_in = gen_state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (bounds_equal) begin
                  // equal bounds: low bound straight out, no advance
                  res_in.int_value = (req_data.kind == lcgrr_pkg::KIND_INT)
                                     ? req_data.int_low : 32'd0;
                  res_in.fix_value = (req_data.kind == lcgrr_pkg::KIND_FIX)
                                     ? req_data.fix_low : 32'sd0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ADV_GO;
               end
            end
         end
         ST_ADV_GO: begin
            state_in = ST_ADV_RUN;
         end
         ST_ADV_RUN: begin
            if (mul_stat.done) begin
               gen_state_in = mul_prod[31:0] + lcgrr_pkg::LCG_INC;
               state_in = (kind_ff == lcgrr_pkg::KIND_FIX) ? ST_PROD_GO : ST_DIV_GO;
            end
         end
         ST_PROD_GO: begin
            state_in = ST_PROD_RUN;
         end
         ST_PROD_RUN: begin
            if (mul_stat.done) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_stat.done) begin
               if (kind_ff == lcgrr_pkg::KIND_FIX) begin
                  res_in.int_value = 32'd0;
                  res_in.fix_value = lo_ff + q_signed;
               end else begin
                  res_in.int_value = lo_ff + div_rem;
                  res_in.fix_value = 32'sd0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the user is bound, the block does not enforce it
      if (csr_take) begin
         case (csr_index)
            lcgrr_pkg::CSR_START: begin
               gen_state_in = (csr_data != 32'd0) ? csr_data : fallback_ff;
            end
            default: begin
               gen_state_in = gen_state_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_state_ff <= 32'd0;
         fallback_ff  <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_state_ff <= gen_state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take && (csr_index == lcgrr_pkg::CSR_FALLBACK)) begin
            fallback_ff <= csr_data;
         end
      end
   end

   // request capture, result and output payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_data.kind;
         lo_ff    <= (req_data.kind == lcgrr_pkg::KIND_FIX)
                     ? req_data.fix_low : req_data.int_low;
         span_ff  <= req_data.int_high - req_data.int_low;
         d_mag_ff <= d_abs;
         d_neg_ff <= d_full[32];
      end
      res_ff <= res_in;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the two serial units never run at the same time
   assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   // a taken request blocks the next one until its result is handed over
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken while another is in flight");

   // a finished result with room at the output appears there next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not moved to output register");

   // equal bounds leave the generator untouched
   assert property (@(posedge clock) disable iff (reset)
      req_take && bounds_equal && !csr_valid |=> $stable(gen_state_ff))
      else $error("generator advanced on equal bounds");

endmodule
